FILE: rtl/agdv_pkg.sv
// Shared constants and types for the and-gate delta varint decoder.
package agdv_pkg;

   // Default widths for literals and counts
   localparam int LiteralWidthDefault = 32;
   localparam int CountWidthDefault   = 24;

   // Varint coding: seven payload bits per byte, bit 7 flags a continuation
   localparam int GroupBits   = 7;
   localparam int MoreFlagBit = 7;

   // Entries in the queue between front and back
   localparam int QueueDepth = 2;

   // Configuration register indexes
   localparam int CsrIndexWidth = 2;

   typedef enum logic [CsrIndexWidth-1:0] {
      CsrInputCount = 2'd0,
      CsrLatchCount = 2'd1,
      CsrGateCount  = 2'd2
   } csr_index_type;

   // Control bits that travel with a finished delta
   typedef struct packed {
      logic second_delta;
      logic last_gate;
   } agdv_ctrl_type;

   localparam int CtrlWidth = $bits(agdv_ctrl_type);

endpackage

FILE: rtl/agdv_front.sv
// Front end: takes bytes, assembles varint deltas and tracks gate position.
module agdv_front #(
   parameter int LITERAL_WIDTH = agdv_pkg::LiteralWidthDefault,
   parameter int COUNT_WIDTH   = agdv_pkg::CountWidthDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_in_byte,
   input  logic [COUNT_WIDTH-1:0]     gate_count,
   input  logic                       queue_full,
   output logic                       push_valid,
   output logic [LITERAL_WIDTH-1:0]   push_number,
   output logic [COUNT_WIDTH-1:0]     push_index,
   output agdv_pkg::agdv_ctrl_type    push_ctrl
);
   import agdv_pkg::*;

   localparam int MaxGroups = (LITERAL_WIDTH + GroupBits - 1) / GroupBits;
   localparam int PosWidth  = $clog2(MaxGroups + 1);
   localparam int AsmWidth  = MaxGroups * GroupBits;

   logic [LITERAL_WIDTH-1:0] partial_ff, partial_in;
   logic [PosWidth-1:0]      position_ff, position_in;
   logic                     second_ff, second_in;
   logic [COUNT_WIDTH-1:0]   index_ff, index_in;

   logic                     accept;
   logic                     take;
   logic                     ends;
   logic [AsmWidth-1:0]      placed;
   logic [LITERAL_WIDTH-1:0] assembled;

   // Accept a beat whenever the queue has room
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign take      = accept && (index_ff < gate_count);
   assign ends      = !req_in_byte[MoreFlagBit];

   // Place the byte's group at its position; groups past the last are dropped
   always_comb begin
      placed = '0;
      for (int g = 0; g < MaxGroups; g++) begin
         if (position_ff == PosWidth'(g)) begin
            placed[g*GroupBits +: GroupBits] = req_in_byte[GroupBits-1:0];
         end
      end
   end

   assign assembled = partial_ff | placed[LITERAL_WIDTH-1:0];

   // Advance varint and gate state
   always_comb begin
      partial_in  = partial_ff;
      position_in = position_ff;
      second_in   = second_ff;
      index_in    = index_ff;
      if (take) begin
         if (ends) begin
            partial_in  = '0;
            position_in = '0;
            second_in   = !second_ff;
            if (second_ff) begin
               index_in = index_ff + COUNT_WIDTH'(1);
            end
         end else begin
            partial_in = assembled;
            if (position_ff < PosWidth'(MaxGroups)) begin
               position_in = position_ff + PosWidth'(1);
            end
         end
      end
   end

   // Hand a finished delta to the back end
   assign push_valid             = take && ends;
   assign push_number            = assembled;
   assign push_index             = index_ff;
   assign push_ctrl.second_delta = second_ff;
   assign push_ctrl.last_gate    =
      ({1'b0, index_ff} + (COUNT_WIDTH+1)'(1)) == {1'b0, gate_count};

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff  <= '0;
         position_ff <= '0;
         second_ff   <= 1'b0;
         index_ff    <= '0;
      end else begin
         partial_ff  <= partial_in;
         position_ff <= position_in;
         second_ff   <= second_in;
         index_ff    <= index_in;
      end
   end

endmodule

FILE: rtl/agdv_queue.sv
// Short queue that decouples the front end from the back end.
module agdv_queue #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_valid,
   input  logic [DATA_WIDTH-1:0] wr_data,
   output logic                  full,
   output logic                  rd_valid,
   output logic [DATA_WIDTH-1:0] rd_data,
   input  logic                  rd_pop
);
   import agdv_pkg::*;

   localparam int PtrWidth   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CountWidth = $clog2(QueueDepth + 1);

   logic [DATA_WIDTH-1:0] entries_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff;
   logic [PtrWidth-1:0]   rd_ptr_ff;
   logic [CountWidth-1:0] count_ff;
   logic                  do_write;
   logic                  do_read;

   assign full     = count_ff == CountWidth'(QueueDepth);
   assign rd_valid = count_ff != '0;
   assign rd_data  = entries_ff[rd_ptr_ff];
   assign do_write = wr_valid && !full;
   assign do_read  = rd_pop && rd_valid;

   // Store an entry at the write pointer
   always_ff @(posedge clock) begin
      if (do_write) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_write) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0
                                                                 : wr_ptr_ff + PtrWidth'(1);
         end
         if (do_read) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0
                                                                 : rd_ptr_ff + PtrWidth'(1);
         end
         if (do_write && !do_read) begin
            count_ff <= count_ff + CountWidth'(1);
         end else if (do_read && !do_write) begin
            count_ff <= count_ff - CountWidth'(1);
         end
      end
   end

endmodule

FILE: rtl/agdv_back.sv
// Back end: turns finished deltas into gate literals and holds the result beat.
module agdv_back #(
   parameter int LITERAL_WIDTH = agdv_pkg::LiteralWidthDefault,
   parameter int COUNT_WIDTH   = agdv_pkg::CountWidthDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [COUNT_WIDTH-1:0]     input_count,
   input  logic [COUNT_WIDTH-1:0]     latch_count,
   input  logic                       entry_valid,
   input  logic [LITERAL_WIDTH-1:0]   entry_number,
   input  logic [COUNT_WIDTH-1:0]     entry_index,
   input  agdv_pkg::agdv_ctrl_type    entry_ctrl,
   output logic                       entry_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [LITERAL_WIDTH-1:0]   rsp_out_literal,
   output logic [LITERAL_WIDTH-1:0]   rsp_first_in_literal,
   output logic [LITERAL_WIDTH-1:0]   rsp_second_in_literal,
   output logic                       rsp_last_gate
);
   import agdv_pkg::*;

   localparam int SumWidth  = COUNT_WIDTH + 2;
   localparam int WideWidth = (LITERAL_WIDTH > SumWidth + 1) ? LITERAL_WIDTH : SumWidth + 1;

   logic [SumWidth-1:0]      sum;
   logic [WideWidth-1:0]     wide_lhs;
   logic [LITERAL_WIDTH-1:0] lhs;
   logic                     out_free;

   logic [LITERAL_WIDTH-1:0] held_first_ff;
   logic                     rsp_valid_ff;
   logic [LITERAL_WIDTH-1:0] rsp_out_literal_ff;
   logic [LITERAL_WIDTH-1:0] rsp_first_in_literal_ff;
   logic [LITERAL_WIDTH-1:0] rsp_second_in_literal_ff;
   logic                     rsp_last_gate_ff;

   // Output literal of the gate: 2 * (inputs + latches + index + 1)
   assign sum = SumWidth'(input_count) + SumWidth'(latch_count)
              + SumWidth'(entry_index) + SumWidth'(1);
   assign wide_lhs = WideWidth'({sum, 1'b0});
   assign lhs      = wide_lhs[LITERAL_WIDTH-1:0];

   // First deltas always drain; second deltas wait for a free output register
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign entry_pop = entry_valid && (!entry_ctrl.second_delta || out_free);

   // Hold the first input literal until the second delta arrives
   always_ff @(posedge clock) begin
      if (entry_pop && !entry_ctrl.second_delta) begin
         held_first_ff <= lhs - entry_number;
      end
   end

   // Load the result beat
   always_ff @(posedge clock) begin
      if (entry_pop && entry_ctrl.second_delta) begin
         rsp_out_literal_ff       <= lhs;
         rsp_first_in_literal_ff  <= held_first_ff;
         rsp_second_in_literal_ff <= held_first_ff - entry_number;
         rsp_last_gate_ff         <= entry_ctrl.last_gate;
      end
   end

   // Track the result beat's valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (entry_pop && entry_ctrl.second_delta) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_out_literal       = rsp_out_literal_ff;
   assign rsp_first_in_literal  = rsp_first_in_literal_ff;
   assign rsp_second_in_literal = rsp_second_in_literal_ff;
   assign rsp_last_gate         = rsp_last_gate_ff;

endmodule

FILE: rtl/and_gate_delta_varint_decoder.sv
// Top level of the and-gate delta varint decoder.
// Takes the and-gate section of a binary graph file one byte per beat and gives
// one result beat per gate: output literal, both input literals and a last-gate
// mark. A byte is accepted every cycle while the queue has room; a result is
// registered in the back end once the byte ending the gate's second delta has
// passed the two-entry queue between front end and back end, which sets the
// rate and keeps taking bytes while a result waits under stall. Bytes that
// arrive after the configured number of gates has been decoded are taken and
// dropped. Write the counts only while no beat is in flight.
module and_gate_delta_varint_decoder #(
   parameter int LITERAL_WIDTH = agdv_pkg::LiteralWidthDefault,
   parameter int COUNT_WIDTH   = agdv_pkg::CountWidthDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_in_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [LITERAL_WIDTH-1:0]           rsp_out_literal,
   output logic [LITERAL_WIDTH-1:0]           rsp_first_in_literal,
   output logic [LITERAL_WIDTH-1:0]           rsp_second_in_literal,
   output logic                               rsp_last_gate,
   input  logic                               csr_write_enable,
   input  logic [agdv_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [COUNT_WIDTH-1:0]             csr_write_data
);
   import agdv_pkg::*;

   localparam int EntryWidth = CtrlWidth + COUNT_WIDTH + LITERAL_WIDTH;

   logic [COUNT_WIDTH-1:0]   input_count_ff;
   logic [COUNT_WIDTH-1:0]   latch_count_ff;
   logic [COUNT_WIDTH-1:0]   gate_count_ff;

   logic                     queue_full;
   logic                     push_valid;
   logic [LITERAL_WIDTH-1:0] push_number;
   logic [COUNT_WIDTH-1:0]   push_index;
   agdv_ctrl_type            push_ctrl;
   logic                     entry_valid;
   logic [EntryWidth-1:0]    entry_data;
   logic                     entry_pop;
   logic [LITERAL_WIDTH-1:0] entry_number;
   logic [COUNT_WIDTH-1:0]   entry_index;
   agdv_ctrl_type            entry_ctrl;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         input_count_ff <= '0;
         latch_count_ff <= '0;
         gate_count_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CsrInputCount: input_count_ff <= csr_write_data;
            CsrLatchCount: latch_count_ff <= csr_write_data;
            CsrGateCount:  gate_count_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   agdv_front #(
      .LITERAL_WIDTH(LITERAL_WIDTH),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_in_byte(req_in_byte),
      .gate_count (gate_count_ff),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_number(push_number),
      .push_index (push_index),
      .push_ctrl  (push_ctrl)
   );

   agdv_queue #(
      .DATA_WIDTH(EntryWidth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_valid(push_valid),
      .wr_data ({push_ctrl, push_index, push_number}),
      .full    (queue_full),
      .rd_valid(entry_valid),
      .rd_data (entry_data),
      .rd_pop  (entry_pop)
   );

   // Unpack the queue entry
   assign entry_number = entry_data[LITERAL_WIDTH-1:0];
   assign entry_index  = entry_data[LITERAL_WIDTH +: COUNT_WIDTH];
   assign entry_ctrl   = entry_data[EntryWidth-1 -: CtrlWidth];

   agdv_back #(
      .LITERAL_WIDTH(LITERAL_WIDTH),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .input_count          (input_count_ff),
      .latch_count          (latch_count_ff),
      .entry_valid          (entry_valid),
      .entry_number         (entry_number),
      .entry_index          (entry_index),
      .entry_ctrl           (entry_ctrl),
      .entry_pop            (entry_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_literal      (rsp_out_literal),
      .rsp_first_in_literal (rsp_first_in_literal),
      .rsp_second_in_literal(rsp_second_in_literal),
      .rsp_last_gate        (rsp_last_gate)
   );

endmodule

FILE: rtl/agdv_checker.sv
// Port-level checks for the and-gate delta varint decoder, bound to the top level.
module agdv_checker #(
   parameter int LITERAL_WIDTH = agdv_pkg::LiteralWidthDefault
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [LITERAL_WIDTH-1:0] rsp_out_literal,
   input logic [LITERAL_WIDTH-1:0] rsp_first_in_literal,
   input logic [LITERAL_WIDTH-1:0] rsp_second_in_literal,
   input logic                     rsp_last_gate
);

   // A gate's output literal is always even
   a_out_even: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_out_literal[0])
      else $error("odd output literal");

   // Reset leaves no result beat pending and takes input at once
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state not cleared by reset");

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_literal)
         && $stable(rsp_first_in_literal) && $stable(rsp_second_in_literal)
         && $stable(rsp_last_gate))
      else $error("stalled result beat changed");

   // The byte side only stalls behind a waiting result beat
   a_stall_behind_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("byte side stalled with no result beat waiting");

endmodule

bind and_gate_delta_varint_decoder agdv_checker #(
   .LITERAL_WIDTH(LITERAL_WIDTH)
) u_agdv_checker (
   .clock                (clock),
   .reset                (reset),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_out_literal      (rsp_out_literal),
   .rsp_first_in_literal (rsp_first_in_literal),
   .rsp_second_in_literal(rsp_second_in_literal),
   .rsp_last_gate        (rsp_last_gate)
);

FILE: verif/and_gate_literal_checker.sv
// Checker for the and-gate delta varint decoder: mirrors the decode and compares result beats.
module and_gate_literal_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [7:0]                         req_in_byte,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [31:0]                        rsp_out_literal,
   input  logic [31:0]                        rsp_first_in_literal,
   input  logic [31:0]                        rsp_second_in_literal,
   input  logic                               rsp_last_gate,
   input  logic                               csr_write_enable,
   input  logic [agdv_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [23:0]                        csr_write_data,
   output int                                 fail_count,
   output int                                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import agdv_pkg::*;

   localparam int LitW      = LiteralWidthDefault;
   localparam int CntW      = CountWidthDefault;
   localparam int MaxGroups = (LitW + GroupBits - 1) / GroupBits;

   typedef struct packed {
      logic [LitW-1:0] out_literal;
      logic [LitW-1:0] first_in_literal;
      logic [LitW-1:0] second_in_literal;
      logic            last_gate;
   } gate_literals_type;

   // Mirror of the register file
   logic [CntW-1:0] cfg_inputs;
   logic [CntW-1:0] cfg_latches;
   logic [CntW-1:0] cfg_gates;

   // Mirror of the decode state
   logic [LitW-1:0] partial_number;
   logic [2:0]      group_count;
   logic            reading_delta1;
   logic [CntW-1:0] gate_number;
   logic [LitW-1:0] held_first;

   gate_literals_type pending_gates[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   task automatic report_mismatch(input string what, input logic [LitW-1:0] got,
                                  input logic [LitW-1:0] want);
      $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
      fail_count++;
   endtask

   // Fold one section byte into the decode state; queue a gate when it completes
   task automatic decode_section_byte(input logic [7:0] data);
      logic [63:0]       node_sum;
      logic [LitW-1:0]   number;
      logic [LitW-1:0]   lhs;
      gate_literals_type gate;
      // drop everything once the section is complete
      if (gate_number >= cfg_gates)
         return;
      if (group_count < MaxGroups) begin
         partial_number = partial_number | (LitW'(data[6:0]) << (GroupBits * group_count));
         group_count    = group_count + 3'd1;
      end
      if (data[MoreFlagBit])
         return;
      number         = partial_number;
      partial_number = '0;
      group_count    = '0;
      node_sum       = 64'(cfg_inputs) + 64'(cfg_latches) + 64'(gate_number) + 64'd1;
      lhs            = LitW'(node_sum << 1);
      if (!reading_delta1) begin
         held_first     = lhs - number;
         reading_delta1 = 1'b1;
         return;
      end
      gate.out_literal       = lhs;
      gate.first_in_literal  = held_first;
      gate.second_in_literal = held_first - number;
      gate.last_gate         = ({1'b0, gate_number} + 1) == {1'b0, cfg_gates};
      pending_gates          = {pending_gates, gate};
      gate_number    = gate_number + 1'b1;
      reading_delta1 = 1'b0;
      held_first     = '0;
   endtask

   always @(posedge clock) begin
      gate_literals_type want;
      if (reset) begin
         cfg_inputs     = '0;
         cfg_latches    = '0;
         cfg_gates      = '0;
         partial_number = '0;
         group_count    = '0;
         reading_delta1 = 1'b0;
         gate_number    = '0;
         held_first     = '0;
         pending_gates.delete();
      end else begin
         // register writes take effect before a byte on the same edge
         if (csr_write_enable) begin
            case (csr_index)
               CsrInputCount: cfg_inputs  = csr_write_data;
               CsrLatchCount: cfg_latches = csr_write_data;
               CsrGateCount:  cfg_gates   = csr_write_data;
               default: ;
            endcase
         end
         // compare a result beat against the oldest predicted gate
         if (rsp_valid && !rsp_stall) begin
            if (pending_gates.size() == 0) begin
               report_mismatch("result beat with no gate pending", rsp_out_literal, '0);
            end else begin
               want = pending_gates.pop_front();
               if (rsp_out_literal !== want.out_literal)
                  report_mismatch("out_literal", rsp_out_literal, want.out_literal);
               if (rsp_first_in_literal !== want.first_in_literal)
                  report_mismatch("first_in_literal", rsp_first_in_literal,
                                  want.first_in_literal);
               if (rsp_second_in_literal !== want.second_in_literal)
                  report_mismatch("second_in_literal", rsp_second_in_literal,
                                  want.second_in_literal);
               if (rsp_last_gate !== want.last_gate)
                  report_mismatch("last_gate", LitW'(rsp_last_gate), LitW'(want.last_gate));
            end
         end
         if (req_valid && !req_stall)
            decode_section_byte(req_in_byte);
      end
      pending_count = pending_gates.size();
   end

endmodule

FILE: verif/and_gate_delta_varint_decoder_tb.sv
// Testbench top for the and-gate delta varint decoder: stimulus, idling and verdict.
module and_gate_delta_varint_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import agdv_pkg::*;

   localparam int CycleLimit  = 200000;
   localparam int SettleDelay = 8;
   localparam int PhaseBytes  = 43;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [7:0]               req_in_byte;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [31:0]              rsp_out_literal;
   logic [31:0]              rsp_first_in_literal;
   logic [31:0]              rsp_second_in_literal;
   logic                     rsp_last_gate;
   logic                     csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [23:0]              csr_write_data;

   int fail_count;
   int pending_count;
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int cycle_count    = 0;
   int bytes_sent     = 0;
   int gates_done     = 0;
   int settings_count = 0;

   and_gate_delta_varint_decoder DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_in_byte           (req_in_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_out_literal       (rsp_out_literal),
      .rsp_first_in_literal  (rsp_first_in_literal),
      .rsp_second_in_literal (rsp_second_in_literal),
      .rsp_last_gate         (rsp_last_gate),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   and_gate_literal_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_in_byte           (req_in_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_out_literal       (rsp_out_literal),
      .rsp_first_in_literal  (rsp_first_in_literal),
      .rsp_second_in_literal (rsp_second_in_literal),
      .rsp_last_gate         (rsp_last_gate),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .fail_count            (fail_count),
      .pending_count         (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver back-pressure
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);

   // Count finished gates and bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         gates_done++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[and_gate_delta_varint_decoder] ERROR");
         $finish;
      end
   end

   // Offer one byte; called and returns at a falling edge with valid still high
   task automatic send_byte(input logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= data;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Send one number: mostly well-formed varints, some overlong runs and raw noise
   task automatic send_number(output int used);
      int          kind;
      int          groups;
      logic [31:0] value;
      kind = $urandom_range(99);
      used = 0;
      if (kind < 86) begin
         if (kind < 40)
            value = $urandom_range(127);
         else if (kind < 70)
            value = $urandom_range(16383);
         else
            value = $urandom();
         do begin
            if (value >> GroupBits != 0)
               send_byte({1'b1, value[6:0]});
            else
               send_byte({1'b0, value[6:0]});
            used++;
            value = value >> GroupBits;
         end while (value != 0);
      end else if (kind < 94) begin
         // overlong: groups past the fifth are dropped
         groups = $urandom_range(8, 5);
         for (int g = 0; g < groups; g++) begin
            send_byte({(g != groups - 1), 7'($urandom())});
            used++;
         end
      end else begin
         send_byte(8'($urandom()));
         used = 1;
      end
   endtask

   // Drop valid, wait for every gate to come out, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0)
         @(negedge clock);
      repeat (SettleDelay) @(negedge clock);
   endtask

   // Write all three counts; called and returns at a falling edge
   task automatic configure(input logic [23:0] inputs, input logic [23:0] latches,
                            input logic [23:0] gates);
      csr_write_enable <= 1'b1;
      csr_index        <= CsrInputCount;
      csr_write_data   <= inputs;
      @(negedge clock);
      csr_index        <= CsrLatchCount;
      csr_write_data   <= latches;
      @(negedge clock);
      csr_index        <= CsrGateCount;
      csr_write_data   <= gates;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings_count++;
   endtask

   function automatic logic [23:0] pick_count();
      case ($urandom_range(3))
         0:       return 24'd0;
         1:       return 24'hFFFFFF;
         2:       return 24'($urandom_range(40));
         default: return 24'($urandom());
      endcase
   endfunction

   // One register setting followed by a burst of numbers
   task automatic run_phase();
      int sent;
      int used;
      int pick;
      pick = $urandom_range(9);
      settle();
      if (pick == 1) begin
         // close the section: these bytes must all be dropped
         configure(pick_count(), pick_count(), 24'(gates_done));
         for (int k = 0; k < 8; k++)
            send_byte(8'($urandom()));
         settle();
      end
      if (pick == 0)
         configure(pick_count(), pick_count(), 24'hFFFFFF);
      else
         configure(pick_count(), pick_count(), 24'(gates_done + $urandom_range(30, 4)));
      sent = 0;
      while (sent < PhaseBytes) begin
         send_number(used);
         sent += used;
      end
   endtask

   initial begin
      logic [7:0] edge_bytes [0:18] = '{
         8'h00, 8'h00,
         8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
         8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01,
         8'h81, 8'h01, 8'h7F,
         8'h55, 8'hAA
      };
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_in_byte      = 8'h00;
      csr_write_enable = 1'b0;
      csr_index        = CsrInputCount;
      csr_write_data   = 24'd0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 13;
      rsp_stall_pct = 52;
      @(negedge clock);

      // gate count still zero from reset: bytes are dropped
      send_byte(8'h80);
      send_byte(8'h00);
      settle();

      // zero deltas, overlong deltas, multi-byte delta, last gate, trailing bytes
      configure(24'd0, 24'd0, 24'd3);
      foreach (edge_bytes[i])
         send_byte(edge_bytes[i]);
      settle();

      // all counts at their maximum
      configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_byte(8'h7F);
      send_byte(8'h00);

      // random part under three idle patterns
      for (int regime = 0; regime < 3; regime++) begin
         case (regime)
            0: begin
               send_idle_pct = 13;
               rsp_stall_pct = 52;
            end
            1: begin
               send_idle_pct = 52;
               rsp_stall_pct = 13;
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         for (int p = 0; p < 4; p++)
            run_phase();
      end

      settle();
      repeat (SettleDelay) @(negedge clock);
      $display("Covered %0d bytes and %0d gate results over %0d register settings,",
               bytes_sent, gates_done, settings_count);
      $display("with sender and receiver idling in turn and then running flat out.");
      if (fail_count == 0)
         $display("[and_gate_delta_varint_decoder] OK");
      else
         $display("[and_gate_delta_varint_decoder] ERROR");
      $finish;
   end

endmodule
